// File: hw/rtl/drpq_pkg.sv
// ----------------------------------------------------------------------------
// drpq_pkg
// Shared types and constants for the dead-region proximity query block.
// ----------------------------------------------------------------------------
package drpq_pkg;

  localparam int NUM_BOUNDS = 256;
  localparam int NUM_PLANES = 3;
  localparam int IDX_W      = $clog2(NUM_BOUNDS);
  localparam int CNT_W      = $clog2(NUM_BOUNDS + 1);
  localparam int ADDR_W     = IDX_W + 2;
  localparam int DEPTH      = NUM_PLANES * NUM_BOUNDS;

  localparam logic [15:0] TOL_RESET = 16'd38;

  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;

  localparam logic [1:0] PLANE_FIRST  = 2'd0;
  localparam logic [1:0] PLANE_SECOND = 2'd1;
  localparam logic [1:0] PLANE_COLL   = 2'd2;
  localparam logic [1:0] PLANE_NONE   = 2'd3;

  typedef struct packed {
    logic [1:0]         kind;
    logic [1:0]         plane;
    logic               is_low;
    logic signed [13:0] y_start;
    logic [16:0]        z_start;
    logic signed [13:0] y_end;
    logic [16:0]        z_end;
    logic signed [13:0] query_y;
    logic [16:0]        query_z;
  } cmd_t;

  typedef struct packed {
    logic               low;
    logic signed [13:0] y_start;
    logic [16:0]        z_start;
    logic signed [13:0] y_end;
    logic [16:0]        z_end;
  } entry_t;

  // per-entry tag that rides along the evaluation pipeline
  typedef struct packed {
    logic       valid;
    logic [1:0] plane;
    logic       first;
  } tag_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] plane;
    logic       first;
    logic       low;
    logic       close;
    logic       side_ok;
    logic       side_neg;
    logic       side_pos;
  } eval_t;

endpackage

// File: hw/rtl/drpq_front.sv
// ----------------------------------------------------------------------------
// drpq_front
// Input side: takes words, drops meaningless commands, pushes the rest.
// ----------------------------------------------------------------------------
module drpq_front (
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [95:0]          s_tdata,   // y_start, z_start, y_end, z_end, query_y, query_z
  input  logic [4:0]           s_tuser,   // command, plane, is_low
  input  logic                 q_full,
  output logic                 q_push,
  output drpq_pkg::cmd_t       q_data
);
  import drpq_pkg::*;

  logic useful;

  always_comb begin
    q_data.kind    = s_tuser[1:0];
    q_data.plane   = s_tuser[3:2];
    q_data.is_low  = s_tuser[4];
    q_data.y_start = s_tdata[13:0];
    q_data.z_start = s_tdata[30:14];
    q_data.y_end   = s_tdata[44:31];
    q_data.z_end   = s_tdata[61:45];
    q_data.query_y = s_tdata[75:62];
    q_data.query_z = s_tdata[92:76];
    case (s_tuser[1:0])
      CMD_CLEAR:  useful = 1'b1;
      CMD_QUERY:  useful = 1'b1;
      CMD_APPEND: useful = (s_tuser[3:2] != PLANE_NONE);
      default:    useful = 1'b0;
    endcase
  end

  assign s_tready = !q_full;
  assign q_push   = s_tvalid && s_tready && useful;

endmodule

// File: hw/rtl/drpq_fifo.sv
// ----------------------------------------------------------------------------
// drpq_fifo
// Two-entry command queue between front and back.
// ----------------------------------------------------------------------------
module drpq_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  drpq_pkg::cmd_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output drpq_pkg::cmd_t pop_data
);
  import drpq_pkg::*;

  cmd_t       slot [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] fill;

  assign full      = (fill == 2'd2);
  assign not_empty = (fill != 2'd0);
  assign pop_data  = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// File: hw/rtl/drpq_eval.sv
// ----------------------------------------------------------------------------
// drpq_eval
// Six-stage per-entry pipeline: exact distance and side tests, one entry
// per cycle.
// ----------------------------------------------------------------------------
module drpq_eval (
  input  logic               clk,
  input  logic               rst,
  input  drpq_pkg::tag_t     in_tag,
  input  drpq_pkg::entry_t   in_entry,
  input  logic signed [13:0] query_y,
  input  logic [16:0]        query_z,
  input  logic [15:0]        tol,
  output drpq_pkg::eval_t    result,
  output logic               busy
);
  import drpq_pkg::*;

  tag_t t1, t2, t3, t4, t5;
  logic l1, l2, l3, l4, l5;

  logic [31:0] tol_sq;

  // stage 1
  logic signed [14:0] a1, dy1;
  logic signed [17:0] b1, dz1;
  // stage 2
  logic signed [32:0] p1_2, p2_2;
  logic [35:0]        dz2_2, dy2_2;
  logic               bclose2, bneg2, bpos2, dzneg2, dznz2;
  // stage 3
  logic [33:0] anum3;
  logic [35:0] den3;
  logic        sneg3, spos3, bclose3, bneg3, bpos3, dznz3;
  // stage 4
  logic [33:0] hh4, hl4, ll4;
  logic [50:0] th4;
  logic [48:0] tl4;
  logic        sneg4, spos4, bclose4, bneg4, bpos4, dznz4;
  // stage 5
  logic [68:0] nsq5, tsq5;
  logic        sneg5, spos5, bclose5, bneg5, bpos5, dznz5;

  logic signed [33:0] num_c;
  logic [17:0]        babs_c;

  always_comb begin
    num_c  = 34'(p1_2) - 34'(p2_2);
    babs_c = b1[17] ? 18'(-b1) : 18'(b1);
  end

  always_ff @(posedge clk) begin
    tol_sq <= tol * tol;

    a1  <= 15'(query_y) - 15'(in_entry.y_start);
    b1  <= $signed({1'b0, query_z}) - $signed({1'b0, in_entry.z_start});
    dz1 <= $signed({1'b0, in_entry.z_end}) - $signed({1'b0, in_entry.z_start});
    dy1 <= 15'(in_entry.y_end) - 15'(in_entry.y_start);
    l1  <= in_entry.low;

    p1_2    <= 33'(a1) * 33'(dz1);
    p2_2    <= 33'(b1) * 33'(dy1);
    dz2_2   <= 36'($signed(36'(dz1)) * $signed(36'(dz1)));
    dy2_2   <= 36'($signed(36'(dy1)) * $signed(36'(dy1)));
    bclose2 <= (babs_c < {2'b00, tol});
    bneg2   <= b1[17];
    bpos2   <= !b1[17] && (b1 != 18'sd0);
    dzneg2  <= dz1[17];
    dznz2   <= (dz1 != 18'sd0);
    l2      <= l1;

    anum3   <= num_c[33] ? 34'(-num_c) : 34'(num_c);
    den3    <= dz2_2 + dy2_2;
    // side of the line is the sign of num, flipped when dz runs backward
    sneg3   <= dzneg2 ? (!num_c[33] && num_c != 34'sd0) : num_c[33];
    spos3   <= dzneg2 ? num_c[33] : (!num_c[33] && num_c != 34'sd0);
    bclose3 <= bclose2; bneg3 <= bneg2; bpos3 <= bpos2; dznz3 <= dznz2;
    l3      <= l2;

    hh4 <= anum3[33:17] * anum3[33:17];
    hl4 <= anum3[33:17] * anum3[16:0];
    ll4 <= anum3[16:0] * anum3[16:0];
    th4 <= tol_sq * den3[35:17];
    tl4 <= tol_sq * den3[16:0];
    sneg4 <= sneg3; spos4 <= spos3; bclose4 <= bclose3;
    bneg4 <= bneg3; bpos4 <= bpos3; dznz4 <= dznz3;
    l4    <= l3;

    nsq5 <= ({35'd0, hh4} << 34) + ({35'd0, hl4} << 18) + {35'd0, ll4};
    tsq5 <= ({18'd0, th4} << 17) + {20'd0, tl4};
    sneg5 <= sneg4; spos5 <= spos4; bclose5 <= bclose4;
    bneg5 <= bneg4; bpos5 <= bpos4; dznz5 <= dznz4;
    l5    <= l4;

    result.plane <= t5.plane;
    result.first <= t5.first;
    result.low   <= l5;
    if (t5.plane == PLANE_COLL) begin
      result.close    <= bclose5;
      result.side_ok  <= 1'b1;
      result.side_neg <= bneg5;
      result.side_pos <= bpos5;
    end else begin
      result.close    <= (nsq5 < tsq5);
      result.side_ok  <= dznz5;
      result.side_neg <= sneg5;
      result.side_pos <= spos5;
    end

    if (rst) begin
      t1.valid <= 1'b0; t2.valid <= 1'b0; t3.valid <= 1'b0;
      t4.valid <= 1'b0; t5.valid <= 1'b0; result.valid <= 1'b0;
    end else begin
      t1 <= in_tag; t2 <= t1; t3 <= t2; t4 <= t3; t5 <= t4;
      result.valid <= t5.valid;
    end
  end

  assign busy = t1.valid | t2.valid | t3.valid | t4.valid | t5.valid | result.valid;

endmodule

// File: hw/rtl/drpq_back.sv
// ----------------------------------------------------------------------------
// drpq_back
// Command execution: boundary table, entry walk, flag reduction, output word.
// ----------------------------------------------------------------------------
module drpq_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  drpq_pkg::cmd_t q_data,
  output logic           q_pop,
  input  logic [15:0]    tol,
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [7:0]     m_tdata
);
  import drpq_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_WALK  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  entry_t mem [DEPTH];

  logic [1:0]         state;
  logic [CNT_W-1:0]   cnt [NUM_PLANES];
  logic               overflow;
  logic [1:0]         walk_plane;
  logic [CNT_W-1:0]   walk_idx;
  logic [CNT_W-1:0]   cnt_sel;
  logic signed [13:0] qy;
  logic [16:0]        qz;

  logic             rd_en;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  logic             wr_en;
  entry_t           rd_entry, wr_entry;
  tag_t             rd_tag;
  logic [IDX_W-1:0] app_idx;

  eval_t ev;
  logic  ev_busy;
  logic  prev_low, prev_ok, prev_neg, prev_pos;
  logic [2:0] hit;
  logic  between, app_full;

  always_comb begin
    case (walk_plane)
      PLANE_FIRST:  cnt_sel = cnt[0];
      PLANE_SECOND: cnt_sel = cnt[1];
      default:      cnt_sel = cnt[2];
    endcase
    case (q_data.plane)
      PLANE_FIRST: begin
        app_full = (cnt[0] == CNT_W'(NUM_BOUNDS));
        app_idx  = cnt[0][IDX_W-1:0];
      end
      PLANE_SECOND: begin
        app_full = (cnt[1] == CNT_W'(NUM_BOUNDS));
        app_idx  = cnt[1][IDX_W-1:0];
      end
      default: begin
        app_full = (cnt[2] == CNT_W'(NUM_BOUNDS));
        app_idx  = cnt[2][IDX_W-1:0];
      end
    endcase
  end

  assign q_pop   = (state == ST_IDLE) && q_valid;
  assign rd_en   = (state == ST_WALK) && (walk_idx < cnt_sel);
  assign rd_addr = {walk_plane, walk_idx[IDX_W-1:0]};
  assign wr_en   = q_pop && (q_data.kind == CMD_APPEND) && !app_full;
  assign wr_addr = {q_data.plane, app_idx};

  always_comb begin
    wr_entry.low     = q_data.is_low;
    wr_entry.y_start = q_data.y_start;
    wr_entry.z_start = q_data.z_start;
    wr_entry.y_end   = q_data.y_end;
    wr_entry.z_end   = q_data.z_end;
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_entry;
    if (rd_en) rd_entry <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_tag.valid <= 1'b0;
    end else begin
      rd_tag.valid <= rd_en;
    end
    rd_tag.plane <= walk_plane;
    rd_tag.first <= (walk_idx == '0);
  end

  drpq_eval u_eval (
    .clk      (clk),
    .rst      (rst),
    .in_tag   (rd_tag),
    .in_entry (rd_entry),
    .query_y  (qy),
    .query_z  (qz),
    .tol      (tol),
    .result   (ev),
    .busy     (ev_busy)
  );

  // low entry followed by this one: point sits between the two lines
  always_comb begin
    between = !ev.first && prev_low && prev_ok && ev.side_ok;
    if (ev.plane == PLANE_FIRST) between = between && !prev_pos && !ev.side_neg;
    else                         between = between && !prev_neg && !ev.side_pos;
  end

  always_ff @(posedge clk) begin
    if (ev.valid) begin
      prev_low <= ev.low;
      prev_ok  <= ev.side_ok;
      prev_neg <= ev.side_neg;
      prev_pos <= ev.side_pos;
    end
    if (q_pop) begin
      qy <= q_data.query_y;
      qz <= q_data.query_z;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      cnt[0]     <= '0;
      cnt[1]     <= '0;
      cnt[2]     <= '0;
      overflow   <= 1'b0;
      walk_plane <= PLANE_FIRST;
      walk_idx   <= '0;
      hit        <= '0;
      m_tvalid   <= 1'b0;
      m_tdata    <= '0;
    end else begin
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      if (ev.valid && (ev.close || between)) begin
        case (ev.plane)
          PLANE_FIRST:  hit[0] <= 1'b1;
          PLANE_SECOND: hit[1] <= 1'b1;
          default:      hit[2] <= 1'b1;
        endcase
      end
      case (state)
        ST_IDLE: begin
          if (q_pop) begin
            case (q_data.kind)
              CMD_CLEAR: begin
                cnt[0]   <= '0;
                cnt[1]   <= '0;
                cnt[2]   <= '0;
                overflow <= 1'b0;
              end
              CMD_APPEND: begin
                if (app_full) overflow <= 1'b1;
                else begin
                  case (q_data.plane)
                    PLANE_FIRST:  cnt[0] <= cnt[0] + CNT_W'(1);
                    PLANE_SECOND: cnt[1] <= cnt[1] + CNT_W'(1);
                    default:      cnt[2] <= cnt[2] + CNT_W'(1);
                  endcase
                end
              end
              default: begin
                walk_plane <= PLANE_FIRST;
                walk_idx   <= '0;
                hit        <= '0;
                state      <= ST_WALK;
              end
            endcase
          end
        end
        ST_WALK: begin
          if (rd_en) walk_idx <= walk_idx + CNT_W'(1);
          else if (walk_plane == PLANE_COLL) state <= ST_DRAIN;
          else begin
            walk_plane <= walk_plane + 2'd1;
            walk_idx   <= '0;
          end
        end
        ST_DRAIN: begin
          if (!rd_tag.valid && !ev_busy) state <= ST_DONE;
        end
        default: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {2'b00, overflow, (hit != 3'b000),
                         ((hit[0] & hit[1]) | (hit[0] & hit[2]) | (hit[1] & hit[2])),
                         hit};
            state    <= ST_IDLE;
          end
        end
      endcase
    end
  end

endmodule

// File: hw/rtl/dead_region_proximity_query_top.sv
// Commands: clear and append are done in the back end's idle state; a query walks the
// filled part of the three plane tables in order, then drains the evaluation pipeline.
// Throughput: one stored entry per cycle through the single-port table read; the back end
// takes no new command until the query's result word is loaded into the output register.
// Reset: tables empty, overflow flag clear, near_tolerance 38; table contents
// are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// dead_region_proximity_query_top
// Boundary tables per wire plane with point proximity queries.
// ----------------------------------------------------------------------------
module dead_region_proximity_query_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [95:0] s_tdata,  // y_start, z_start, y_end, z_end, query_y, query_z
  input  logic [4:0]  s_tuser,  // command[1:0], plane[3:2], is_low[4]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,  // near_first, near_second, near_collection,
                                // near_two, near_any, table_overflow
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import drpq_pkg::*;

  logic [15:0] near_tolerance;
  logic        q_push, q_full, q_pop, q_valid;
  cmd_t        q_in, q_out;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {16'd0, near_tolerance} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      near_tolerance <= TOL_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
      near_tolerance <= pwdata[15:0];
    end
  end

  drpq_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_in)
  );

  drpq_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_data  (q_out)
  );

  drpq_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_data   (q_out),
    .q_pop    (q_pop),
    .tol      (near_tolerance),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

// File: hw/rtl/drpq_checker.sv
// ----------------------------------------------------------------------------
// drpq_checker
// Port-level checks on the result stream.
// ----------------------------------------------------------------------------
module drpq_checker (
  input logic       clk,
  input logic       rst,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata
);

  a_any: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[4] == (m_tdata[0] | m_tdata[1] | m_tdata[2])))
    else $error("near_any disagrees with plane flags");

  a_two: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[3] == ($countones(m_tdata[2:0]) >= 2)))
    else $error("near_two disagrees with plane flags");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result word changed");

  a_rst: assert property (@(posedge clk)
    $past(rst) && !rst |-> !m_tvalid)
    else $error("result valid right after reset");

endmodule

bind dead_region_proximity_query_top drpq_checker u_drpq_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// File: dv/dead_region_proximity_query_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dead_region_proximity_query_top_test
// Fills the three plane boundary tables through the stream input, queries
// points against them and checks every flag word against a predictor that
// mirrors the tables and does the exact integer distance and side tests.
// ----------------------------------------------------------------------------
module dead_region_proximity_query_top_test;
  import drpq_pkg::*;

  localparam logic [1:0] CMD_NOP  = 2'd3;
  localparam logic [2:0] REG_TOL  = 3'd0;
  localparam int         LIMIT    = 3000000;
  localparam int         SETTLE   = 40;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [95:0] s_tdata = '0;
  logic [4:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  dead_region_proximity_query_top dut (.*);

  always #5 clk = ~clk;

  // mirrored boundary tables
  logic signed [13:0] tab_ys [DEPTH];
  logic [16:0]        tab_zs [DEPTH];
  logic signed [13:0] tab_ye [DEPTH];
  logic [16:0]        tab_ze [DEPTH];
  logic               tab_low [DEPTH];
  int                 fill [NUM_PLANES];
  logic               ovf;
  logic [15:0]        tol;

  logic [5:0] flags_due [$];
  int fail_cnt = 0;
  int send_idle = 0;
  int recv_idle = 0;
  int cycles = 0;

  function automatic bit line_close(int e, longint y, longint z);
    longint dz, dy, num;
    logic [127:0] anum, den, lhs, rhs;
    dz = longint'(tab_ze[e]) - longint'(tab_zs[e]);
    dy = longint'(tab_ye[e]) - longint'(tab_ys[e]);
    if (dz == 0 && dy == 0) return 1'b0;
    num = (y - tab_ys[e]) * dz - (z - longint'(tab_zs[e])) * dy;
    anum = (num < 0) ? 128'(-num) : 128'(num);
    den = 128'(dz * dz) + 128'(dy * dy);
    lhs = anum * anum;
    rhs = 128'(tol) * 128'(tol) * den;
    return lhs < rhs;
  endfunction

  // side of (z, y) against the entry line; ok is 0 for a vertical line
  function automatic bit line_side(int e, longint y, longint z, output int side);
    longint dz, dy, l, r;
    dz = longint'(tab_ze[e]) - longint'(tab_zs[e]);
    dy = longint'(tab_ye[e]) - longint'(tab_ys[e]);
    side = 0;
    if (dz == 0) return 1'b0;
    if (dz < 0) begin
      dz = -dz;
      dy = -dy;
    end
    l = (y - tab_ys[e]) * dz;
    r = (z - longint'(tab_zs[e])) * dy;
    side = (l > r) ? 1 : (l < r) ? -1 : 0;
    return 1'b1;
  endfunction

  function automatic bit slanted_hit(int p, longint y, longint z);
    int s1, s2, e;
    bit hit;
    hit = 1'b0;
    for (int i = 0; i < fill[p]; i++) begin
      e = p * NUM_BOUNDS + i;
      if (line_close(e, y, z)) hit = 1'b1;
      if (tab_low[e] && i + 1 < fill[p] && line_side(e, y, z, s1) &&
          line_side(e + 1, y, z, s2)) begin
        if (p == 0 ? (s1 <= 0 && s2 >= 0) : (s1 >= 0 && s2 <= 0)) hit = 1'b1;
      end
    end
    return hit;
  endfunction

  function automatic bit collection_hit(longint z);
    longint d;
    int e;
    bit hit;
    hit = 1'b0;
    for (int i = 0; i < fill[2]; i++) begin
      e = 2 * NUM_BOUNDS + i;
      d = z - longint'(tab_zs[e]);
      if (d < 0) d = -d;
      if (d < longint'(tol)) hit = 1'b1;
      if (tab_low[e] && i + 1 < fill[2] && z >= tab_zs[e] && z <= tab_zs[e + 1])
        hit = 1'b1;
    end
    return hit;
  endfunction

  task automatic predict_word(logic [1:0] cmd, logic [1:0] pl, logic low,
                              logic signed [13:0] ys, logic [16:0] zs,
                              logic signed [13:0] ye, logic [16:0] ze,
                              logic signed [13:0] qy, logic [16:0] qz);
    bit f0, f1, f2;
    int e, sum;
    case (cmd)
      CMD_CLEAR: begin
        fill = '{0, 0, 0};
        ovf = 1'b0;
      end
      CMD_APPEND: begin
        if (pl != PLANE_NONE) begin
          if (fill[pl] >= NUM_BOUNDS) ovf = 1'b1;
          else begin
            e = pl * NUM_BOUNDS + fill[pl];
            tab_low[e] = low;
            tab_ys[e] = ys;
            tab_zs[e] = zs;
            tab_ye[e] = ye;
            tab_ze[e] = ze;
            fill[pl]++;
          end
        end
      end
      CMD_QUERY: begin
        f0 = slanted_hit(0, qy, qz);
        f1 = slanted_hit(1, qy, qz);
        f2 = collection_hit(qz);
        sum = f0 + f1 + f2;
        flags_due.insert(flags_due.size(), {ovf, sum >= 1, sum >= 2, f2, f1, f0});
      end
      default: ;
    endcase
  endtask

  task automatic send_word(logic [1:0] cmd, logic [1:0] pl, logic low,
                           logic signed [13:0] ys, logic [16:0] zs,
                           logic signed [13:0] ye, logic [16:0] ze,
                           logic signed [13:0] qy, logic [16:0] qz);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= {low, pl, cmd};
    s_tdata <= {3'b0, qz, qy, ze, ye, zs, ys};
    do @(posedge clk); while (!s_tready);
    predict_word(cmd, pl, low, ys, zs, ye, ze, qy, qz);
  endtask

  task automatic add_bound(logic [1:0] pl, logic low, int ys, int zs, int ye, int ze);
    send_word(CMD_APPEND, pl, low, 14'(ys), 17'(zs), 14'(ye), 17'(ze),
              14'($urandom), 17'($urandom));
  endtask

  task automatic ask_point(int qy, int qz);
    send_word(CMD_QUERY, 2'($urandom), 1'($urandom), 14'($urandom), 17'($urandom),
              14'($urandom), 17'($urandom), 14'(qy), 17'(qz));
  endtask

  task automatic wipe();
    send_word(CMD_CLEAR, 2'($urandom), 1'($urandom), 14'($urandom), 17'($urandom),
              14'($urandom), 17'($urandom), 14'($urandom), 17'($urandom));
  endtask

  // waits for the block to drain, then writes the tolerance register
  task automatic set_tol(logic [15:0] v);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (flags_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= REG_TOL;
    pwdata <= {16'($urandom_range(65535)), v};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    tol = v;
  endtask

  // result words
  always @(posedge clk) begin
    if (!rst) begin
      m_tready <= ($urandom_range(99) >= recv_idle);
      if (m_tvalid && m_tready) begin
        if (flags_due.size() == 0) begin
          $display("%0t: unexpected word, expected none, actual %b", $time, m_tdata);
          fail_cnt++;
        end else begin
          if (m_tdata != {2'b0, flags_due[0]}) begin
            $display("%0t: flags mismatch, expected %b, actual %b", $time,
                     {2'b0, flags_due[0]}, m_tdata);
            fail_cnt++;
          end
          void'(flags_due.pop_front());
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic test_empty();
    ask_point(-8192, 0);
    ask_point(8191, 131071);
  endtask

  task automatic test_slanted();
    // first plane: low line above, next line below, point between
    add_bound(PLANE_FIRST, 1'b1, 1000, 1000, 1200, 3000);
    add_bound(PLANE_FIRST, 1'b0, 200, 1000, 400, 3000);
    // second plane: low below, next above; then a vertical and a zero-length one
    add_bound(PLANE_SECOND, 1'b1, 200, 1000, 400, 3000);
    add_bound(PLANE_SECOND, 1'b0, 1000, 1000, 1200, 3000);
    add_bound(PLANE_SECOND, 1'b1, -8192, 5000, 8191, 5000);
    add_bound(PLANE_SECOND, 1'b1, 100, 7000, 100, 7000);
    ask_point(700, 2000);
    ask_point(1110, 2000);
    ask_point(-300, 5020);
    ask_point(100, 7000);
    ask_point(-8192, 131071);
  endtask

  task automatic test_collection();
    add_bound(PLANE_COLL, 1'b1, 0, 20000, 0, 0);
    add_bound(PLANE_COLL, 1'b0, 0, 20500, 0, 0);
    add_bound(PLANE_COLL, 1'b1, 0, 131071, 0, 0);
    ask_point(0, 20250);
    ask_point(0, 20537);
    ask_point(0, 131040);
  endtask

  task automatic test_tolerance();
    set_tol(16'd0);
    ask_point(700, 2000);
    ask_point(1100, 2000);
    ask_point(0, 20000);
    set_tol(16'hFFFF);
    ask_point(8191, 0);
    ask_point(-8192, 131071);
    set_tol(TOL_RESET);
  endtask

  task automatic test_overflow();
    wipe();
    for (int i = 0; i <= NUM_BOUNDS; i++)
      add_bound(PLANE_SECOND, i[0], $urandom_range(200) - 100, 4 * i, 50, 4 * i + 3);
    ask_point(0, 500);
    wipe();
    add_bound(PLANE_NONE, 1'b1, 0, 100, 0, 200);
    ask_point(0, 150);
  endtask

  task automatic test_noise();
    send_word(CMD_NOP, 2'($urandom), 1'($urandom), 14'($urandom), 17'($urandom),
              14'($urandom), 17'($urandom), 14'($urandom), 17'($urandom));
    ask_point(0, 0);
  endtask

  // runs of appends around one region followed by queries near them
  task automatic test_random(int items);
    int n, bz, by, zs, ys, dz;
    n = 0;
    while (n < items) begin
      if ($urandom_range(9) < 8) begin
        wipe();
        n++;
      end
      bz = $urandom_range(3000, 128000);
      by = $urandom_range(14000) - 7000;
      repeat ($urandom_range(0, 8)) begin
        case ($urandom_range(9))
          0: add_bound(2'($urandom), 1'($urandom), $urandom, $urandom, $urandom,
                       $urandom);
          1: send_word(CMD_NOP, 2'($urandom), 1'($urandom), 14'($urandom),
                       17'($urandom), 14'($urandom), 17'($urandom), 14'($urandom),
                       17'($urandom));
          default: begin
            zs = bz + $urandom_range(1000) - 500;
            ys = by + $urandom_range(600) - 300;
            dz = ($urandom_range(9) == 0) ? 0 : $urandom_range(3000) - 1500;
            add_bound(2'($urandom_range(2)), 1'($urandom), ys, zs,
                      ys + $urandom_range(600) - 300, zs + dz);
          end
        endcase
        n++;
      end
      repeat ($urandom_range(1, 5)) begin
        if ($urandom_range(9) == 0) ask_point($urandom, $urandom);
        else ask_point(by + $urandom_range(800) - 400, bz + $urandom_range(2000) - 1000);
        n++;
      end
    end
  endtask

  initial begin
    fill = '{0, 0, 0};
    ovf = 1'b0;
    tol = TOL_RESET;
    send_idle = 19;
    recv_idle = 55;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_empty();
    test_slanted();
    test_collection();
    test_tolerance();
    test_overflow();
    test_noise();
    test_random(160);
    set_tol(16'd1);
    send_idle = 55;
    recv_idle = 19;
    test_random(160);
    set_tol(16'($urandom_range(20, 400)));
    send_idle = 0;
    recv_idle = 0;
    test_random(160);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (flags_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (fail_cnt == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
